>>> hw/rtl/nsfa_pkg.sv
// shared types, constants and width helpers for the nearest source face assign block
package nsfa_pkg;

    localparam int MAX_SOURCES_DEF = 64;
    localparam int MAX_VERTS_DEF   = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam int COORD_W = 32;
    localparam int FACE_W  = 20;
    localparam int SIDX_W  = 6;
    localparam int OIDX_W  = 6;
    localparam int NS_W    = 7;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 32;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_VERTEX = 1'b1
    } func_t;

    typedef enum logic {
        JOB_LOAD = 1'b0,
        JOB_FACE = 1'b1
    } job_kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic int sum_bits(int mv);
        return COORD_W + 1 + $clog2(mv);
    endfunction

    function automatic int job_bits(int ms, int mv);
        return 1 + FACE_W + $clog2(mv + 1) + $clog2(ms) + 3 * sum_bits(mv);
    endfunction

endpackage

>>> hw/rtl/nsfa_front.sv
// front end: accepts requests, sums face vertices and queues loads and face searches
module nsfa_front #(
    parameter int MAX_SOURCES = nsfa_pkg::MAX_SOURCES_DEF,
    parameter int MAX_VERTS   = nsfa_pkg::MAX_VERTS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  nsfa_pkg::func_t                                func,
    input  logic [nsfa_pkg::SIDX_W-1:0]                    source_index,
    input  logic signed [nsfa_pkg::COORD_W-1:0]            coord_x,
    input  logic signed [nsfa_pkg::COORD_W-1:0]            coord_y,
    input  logic signed [nsfa_pkg::COORD_W-1:0]            coord_z,
    input  logic [nsfa_pkg::FACE_W-1:0]                    face_id,
    input  logic                                           last_vertex,
    input  nsfa_pkg::q_status_t                            q_status,
    output logic                                           q_push,
    output logic [nsfa_pkg::job_bits(MAX_SOURCES, MAX_VERTS)-1:0] q_wdata
);
    import nsfa_pkg::*;

    localparam int AW    = $clog2(MAX_SOURCES);
    localparam int VCW   = $clog2(MAX_VERTS + 1);
    localparam int SUM_W = sum_bits(MAX_VERTS);

    typedef struct packed {
        job_kind_t                kind;
        logic [FACE_W-1:0]        face;
        logic [VCW-1:0]           n;
        logic [AW-1:0]            idx;
        logic signed [SUM_W-1:0]  x;
        logic signed [SUM_W-1:0]  y;
        logic signed [SUM_W-1:0]  z;
    } job_t;

    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
    logic [VCW-1:0]          cnt_reg, cnt_next;
    logic                    accept, is_load, idx_ok, can_add;
    job_t                    job;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign is_load  = (func == FUNC_LOAD);
    assign idx_ok   = int'(source_index) < MAX_SOURCES;
    assign can_add  = cnt_reg < VCW'(MAX_VERTS);

    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sum_z_next = sum_z_reg;
        cnt_next   = cnt_reg;
        if (can_add)
        begin
            sum_x_next = sum_x_reg + SUM_W'(coord_x);
            sum_y_next = sum_y_reg + SUM_W'(coord_y);
            sum_z_next = sum_z_reg + SUM_W'(coord_z);
            cnt_next   = cnt_reg + VCW'(1);
        end
    end

    always_comb
    begin
        job.kind = is_load ? JOB_LOAD : JOB_FACE;
        job.face = face_id;
        job.n    = cnt_next;
        job.idx  = AW'(source_index);
        job.x    = is_load ? SUM_W'(coord_x) : sum_x_next;
        job.y    = is_load ? SUM_W'(coord_y) : sum_y_next;
        job.z    = is_load ? SUM_W'(coord_z) : sum_z_next;
    end

    assign q_wdata = job;
    assign q_push  = accept && (is_load ? idx_ok : last_vertex);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (accept && !is_load)
        begin
            if (last_vertex)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_z_reg <= '0;
                cnt_reg   <= '0;
            end
            else
            begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                sum_z_reg <= sum_z_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

>>> hw/rtl/nsfa_queue.sv
// short job queue between front end and search engine
module nsfa_queue #(
    parameter int W     = 8,
    parameter int DEPTH = nsfa_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [W-1:0]        wdata,
    input  logic                pop,
    output logic [W-1:0]        rdata,
    output nsfa_pkg::q_status_t status
);
    import nsfa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rdata        = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

>>> hw/rtl/nsfa_back.sv
// search engine: source store, pipelined squared distance and running minimum
module nsfa_back #(
    parameter int MAX_SOURCES = nsfa_pkg::MAX_SOURCES_DEF,
    parameter int MAX_VERTS   = nsfa_pkg::MAX_VERTS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic [nsfa_pkg::NS_W-1:0]                      num_sources,
    input  nsfa_pkg::q_status_t                            q_status,
    input  logic [nsfa_pkg::job_bits(MAX_SOURCES, MAX_VERTS)-1:0] q_rdata,
    output logic                                           q_pop,
    output logic                                           m_valid,
    input  logic                                           m_ready,
    output logic [nsfa_pkg::FACE_W-1:0]                    face_number,
    output logic [nsfa_pkg::OIDX_W-1:0]                    near_src
);
    import nsfa_pkg::*;

    localparam int AW    = $clog2(MAX_SOURCES);
    localparam int CW    = AW + 1;
    localparam int VCW   = $clog2(MAX_VERTS + 1);
    localparam int SUM_W = sum_bits(MAX_VERTS);
    localparam int PW    = COORD_W + VCW + 1;
    localparam int DW    = COORD_W + $clog2(MAX_VERTS) + 1;
    localparam int LW    = DW / 2;
    localparam int HW    = DW - LW;
    localparam int SQW   = 2 * DW;
    localparam int DSW   = SQW + 2;

    typedef struct packed {
        job_kind_t                kind;
        logic [FACE_W-1:0]        face;
        logic [VCW-1:0]           n;
        logic [AW-1:0]            idx;
        logic signed [SUM_W-1:0]  x;
        logic signed [SUM_W-1:0]  y;
        logic signed [SUM_W-1:0]  z;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    job_t   head;
    state_t state_reg;

    logic [3*COORD_W-1:0] store_mem [MAX_SOURCES];

    logic [CW-1:0]           ns_eff, rd_cnt_reg;
    logic                    issue, done, out_load;
    logic [FACE_W-1:0]       face_reg;
    logic [VCW-1:0]          n_reg;
    logic signed [SUM_W-1:0] sum_reg [3];

    logic                    p1_vld, p2_vld, p3_vld, p4_vld, p5_vld;
    logic                    p1_last, p2_last, p3_last, p4_last, p5_last;
    logic [AW-1:0]           p1_idx, p2_idx, p3_idx, p4_idx, p5_idx;
    logic [3*COORD_W-1:0]    rd_word_reg;
    logic [DW-1:0]           mag_reg [3];
    logic [DW-1:0]           mag_next [3];
    logic [2*HW-1:0]         hh_reg [3];
    logic [HW+LW-1:0]        hl_reg [3];
    logic [2*LW-1:0]         ll_reg [3];
    logic [SQW-1:0]          sq_reg [3];
    logic [DSW-1:0]          dist_reg, best_d_reg;
    logic [AW-1:0]           best_idx_reg;

    assign head = q_rdata;

    always_comb
    begin
        if (num_sources == '0)
        begin
            ns_eff = CW'(1);
        end
        else if (int'(num_sources) > MAX_SOURCES)
        begin
            ns_eff = CW'(MAX_SOURCES);
        end
        else
        begin
            ns_eff = CW'(num_sources);
        end
    end

    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign issue    = (state_reg == ST_SEARCH) && (rd_cnt_reg != ns_eff);
    assign done     = p5_vld && p5_last;
    assign out_load = (state_reg == ST_FINISH) && (!m_valid || m_ready);

    // source store
    always_ff @(posedge clk)
    begin
        if (q_pop && head.kind == JOB_LOAD)
        begin
            store_mem[head.idx] <= {head.z[COORD_W-1:0], head.y[COORD_W-1:0],
                                    head.x[COORD_W-1:0]};
        end
        if (issue)
        begin
            rd_word_reg <= store_mem[rd_cnt_reg[AW-1:0]];
        end
    end

    // face job latch
    always_ff @(posedge clk)
    begin
        if (q_pop && head.kind == JOB_FACE)
        begin
            face_reg   <= head.face;
            n_reg      <= head.n;
            sum_reg[0] <= head.x;
            sum_reg[1] <= head.y;
            sum_reg[2] <= head.z;
        end
    end

    // pipeline valid and last flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld <= 1'b0;
            p2_vld <= 1'b0;
            p3_vld <= 1'b0;
            p4_vld <= 1'b0;
            p5_vld <= 1'b0;
        end
        else
        begin
            p1_vld <= issue;
            p2_vld <= p1_vld;
            p3_vld <= p2_vld;
            p4_vld <= p3_vld;
            p5_vld <= p4_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_last <= (rd_cnt_reg == ns_eff - CW'(1));
        p1_idx  <= rd_cnt_reg[AW-1:0];
        p2_last <= p1_last;
        p2_idx  <= p1_idx;
        p3_last <= p2_last;
        p3_idx  <= p2_idx;
        p4_last <= p3_last;
        p4_idx  <= p3_idx;
        p5_last <= p4_last;
        p5_idx  <= p4_idx;
    end

    // n * source minus vertex sum, magnitude per axis
    always_comb
    begin
        logic signed [COORD_W-1:0] src;
        logic signed [PW-1:0]      prod;
        logic signed [DW:0]        diff;
        for (int a = 0; a < 3; a++)
        begin
            src         = rd_word_reg[a*COORD_W +: COORD_W];
            prod        = $signed({1'b0, n_reg}) * src;
            diff        = (DW+1)'(prod) - (DW+1)'(sum_reg[a]);
            mag_next[a] = diff[DW] ? DW'(-diff) : DW'(diff);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            mag_reg[a] <= mag_next[a];
            hh_reg[a]  <= mag_reg[a][DW-1:LW] * mag_reg[a][DW-1:LW];
            hl_reg[a]  <= mag_reg[a][DW-1:LW] * mag_reg[a][LW-1:0];
            ll_reg[a]  <= mag_reg[a][LW-1:0] * mag_reg[a][LW-1:0];
            sq_reg[a]  <= (SQW'(hh_reg[a]) << (2 * LW)) + (SQW'(hl_reg[a]) << (LW + 1))
                          + SQW'(ll_reg[a]);
        end
        dist_reg <= DSW'(sq_reg[0]) + DSW'(sq_reg[1]) + DSW'(sq_reg[2]);
    end

    // running minimum, lower index wins ties
    always_ff @(posedge clk)
    begin
        if (p5_vld && (p5_idx == '0 || dist_reg < best_d_reg))
        begin
            best_d_reg   <= dist_reg;
            best_idx_reg <= p5_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            m_valid     <= 1'b0;
            face_number <= '0;
            near_src    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid     <= 1'b1;
                face_number <= face_reg;
                near_src    <= OIDX_W'(best_idx_reg);
            end
            else if (m_ready)
            begin
                m_valid <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop && head.kind == JOB_FACE)
                    begin
                        rd_cnt_reg <= '0;
                        state_reg  <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (issue)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CW'(1);
                    end
                    if (done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (rd_cnt_reg <= ns_eff))
        else $error("read count past source count");

    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_SEARCH))
        else $error("search end outside search");

    a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SEARCH) |-> !(p1_vld || p2_vld || p3_vld || p4_vld || p5_vld))
        else $error("distance pipeline busy outside search");

endmodule

>>> hw/rtl/nearest_source_face_assign_core.sv
// top level of the nearest source face assign block
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   vertex or source load request
// m_*       out  m_tvalid/m_tready   face number and nearest source
// cfg_*     in   cfg_we              num_sources register
//
// a load only writes the source store in the search engine, a non-last vertex makes no job
// a last vertex starts a search that reads one stored source per cycle
// through a five stage distance pipeline and the running minimum to the output register
// the front end takes one request per cycle while the two entry job queue has room
// reset clears sums, queue, pipeline and output; the source store is not cleared
module nearest_source_face_assign_core
    import nsfa_pkg::*;
#(
    parameter int MAX_SOURCES = MAX_SOURCES_DEF,
    parameter int MAX_VERTS   = MAX_VERTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // source_index, coord_x, coord_y, coord_z, face_id, zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // face_number, near_src, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [NS_W-1:0]       cfg_wdata
);

    localparam int JOB_W = job_bits(MAX_SOURCES, MAX_VERTS);

    logic [NS_W-1:0]   num_sources_reg;
    q_status_t         q_status;
    logic              q_push, q_pop;
    logic [JOB_W-1:0]  q_wdata, q_rdata;
    logic [FACE_W-1:0] face_number;
    logic [OIDX_W-1:0] near_src;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sources_reg <= NS_W'(1);
        end
        else if (cfg_we)
        begin
            num_sources_reg <= cfg_wdata;
        end
    end

    nsfa_front #(
        .MAX_SOURCES (MAX_SOURCES),
        .MAX_VERTS   (MAX_VERTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .func         (func_t'(s_tuser)),
        .source_index (s_tdata[SIDX_W-1:0]),
        .coord_x      (s_tdata[SIDX_W +: COORD_W]),
        .coord_y      (s_tdata[SIDX_W + COORD_W +: COORD_W]),
        .coord_z      (s_tdata[SIDX_W + 2*COORD_W +: COORD_W]),
        .face_id      (s_tdata[SIDX_W + 3*COORD_W +: FACE_W]),
        .last_vertex  (s_tlast),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    nsfa_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    nsfa_back #(
        .MAX_SOURCES (MAX_SOURCES),
        .MAX_VERTS   (MAX_VERTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_sources (num_sources_reg),
        .q_status    (q_status),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .face_number (face_number),
        .near_src    (near_src)
    );

    assign m_tdata = {(M_TDATA_W - FACE_W - OIDX_W)'(0), near_src, face_number};

endmodule

>>> test/tb.sv
// testbench for nearest_source_face_assign_core: random requests checked against a predictor
`timescale 1ns / 1ps

module tb;
    import nsfa_pkg::*;

    typedef struct {
        func_t                      func;
        logic [SIDX_W-1:0]          slot;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [FACE_W-1:0]          face;
        logic                       last;
    } request_t;

    typedef struct {
        logic [FACE_W-1:0]  face;
        logic [OIDX_W-1:0]  source;
    } face_assign_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [NS_W-1:0]       cfg_wdata = '0;

    request_t      request_queue[$];
    face_assign_t  expected_assign[$];
    request_t      cur_req;
    int            tx_gap;
    bit            tx_calm;
    int            queued;
    int            fail_count;

    // predictor state
    logic signed [COORD_W-1:0]  src_x[MAX_SOURCES_DEF];
    logic signed [COORD_W-1:0]  src_y[MAX_SOURCES_DEF];
    logic signed [COORD_W-1:0]  src_z[MAX_SOURCES_DEF];
    longint                     acc_x;
    longint                     acc_y;
    longint                     acc_z;
    int                         vert_count;
    int                         ns_reg;

    // stimulus-side copy of the store, used to aim vertices at sources
    logic signed [COORD_W-1:0]  gen_x[MAX_SOURCES_DEF];
    logic signed [COORD_W-1:0]  gen_y[MAX_SOURCES_DEF];
    logic signed [COORD_W-1:0]  gen_z[MAX_SOURCES_DEF];

    int  rx_gap;
    int  hold_left;
    int  results_seen;
    int  rx_cyc;
    bit  hold_done;
    bit  rx_calm;

    nearest_source_face_assign_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int searched_count(int v);
        if (v < 1)
            return 1;
        if (v > MAX_SOURCES_DEF)
            return MAX_SOURCES_DEF;
        return v;
    endfunction

    function automatic logic [71:0] square_of(longint d);
        logic [71:0] m;
        m = (d < 0) ? -d : d;
        return m * m;
    endfunction

    function automatic logic [71:0] face_distance(int j, int n);
        return square_of(n * longint'(src_x[j]) - acc_x)
             + square_of(n * longint'(src_y[j]) - acc_y)
             + square_of(n * longint'(src_z[j]) - acc_z);
    endfunction

    task automatic apply_request(input request_t r);
        int           lim;
        int           best;
        logic [71:0]  best_d;
        logic [71:0]  d;
        face_assign_t ea;
        if (r.func == FUNC_LOAD)
        begin
            src_x[r.slot] = r.x;
            src_y[r.slot] = r.y;
            src_z[r.slot] = r.z;
        end
        else
        begin
            if (vert_count < MAX_VERTS_DEF)
            begin
                acc_x += r.x;
                acc_y += r.y;
                acc_z += r.z;
                vert_count++;
            end
            if (r.last)
            begin
                lim = searched_count(ns_reg);
                best = 0;
                best_d = face_distance(0, vert_count);
                for (int j = 1; j < lim; j++)
                begin
                    d = face_distance(j, vert_count);
                    if (d < best_d)
                    begin
                        best_d = d;
                        best = j;
                    end
                end
                ea.face = r.face;
                ea.source = best[OIDX_W-1:0];
                expected_assign.insert(expected_assign.size(), ea);
                acc_x = 0;
                acc_y = 0;
                acc_z = 0;
                vert_count = 0;
            end
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(cur_req);
                tx_gap = pick_gap(tx_calm);
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    cur_req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_req.func;
                    s_tlast <= cur_req.last;
                    s_tdata <= {6'b0, cur_req.face, cur_req.z, cur_req.y, cur_req.x,
                                cur_req.slot};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        face_assign_t exp_a;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_assign.size() == 0)
                begin
                    $error("unexpected result: face_number %0d near_src %0d",
                           m_tdata[FACE_W-1:0], m_tdata[FACE_W +: OIDX_W]);
                    fail_count++;
                end
                else
                begin
                    exp_a = expected_assign.pop_front();
                    if (m_tdata[FACE_W-1:0] !== exp_a.face)
                    begin
                        $error("face_number: expected %0d, actual %0d",
                               exp_a.face, m_tdata[FACE_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[FACE_W +: OIDX_W] !== exp_a.source)
                    begin
                        $error("near_src: expected %0d, actual %0d",
                               exp_a.source, m_tdata[FACE_W +: OIDX_W]);
                        fail_count++;
                    end
                end
                if (results_seen == 20 && !hold_done)
                begin
                    hold_left = 1500;
                    hold_done = 1'b1;
                end
                else
                begin
                    rx_gap = pick_gap(rx_calm);
                end
            end
            rx_cyc++;
            if (rx_cyc % 400 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        if ($urandom_range(0, 1))
            return $urandom;
        return int'($urandom_range(0, 2097151)) - 1048576;
    endfunction

    function automatic int jitter();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic push_load(input logic [SIDX_W-1:0] slot,
                             input logic signed [COORD_W-1:0] x, y, z);
        request_t r;
        r.func = FUNC_LOAD;
        r.slot = slot;
        r.x = x;
        r.y = y;
        r.z = z;
        r.face = $urandom_range(0, 20'hFFFFF);
        r.last = $urandom_range(0, 1);
        gen_x[slot] = x;
        gen_y[slot] = y;
        gen_z[slot] = z;
        request_queue.insert(request_queue.size(), r);
        queued++;
    endtask

    task automatic push_vertex(input logic signed [COORD_W-1:0] x, y, z,
                               input logic [FACE_W-1:0] face, input logic last);
        request_t r;
        r.func = FUNC_VERTEX;
        r.slot = $urandom_range(0, 63);
        r.x = x;
        r.y = y;
        r.z = z;
        r.face = face;
        r.last = last;
        request_queue.insert(request_queue.size(), r);
        queued++;
    endtask

    task automatic push_face(input int nv, input int lim);
        logic signed [COORD_W-1:0] x, y, z;
        int r;
        int k;
        for (int i = 0; i < nv; i++)
        begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, lim - 1);
            if (r < 40)
            begin
                x = gen_x[k] + jitter();
                y = gen_y[k] + jitter();
                z = gen_z[k] + jitter();
            end
            else if (r < 60)
            begin
                x = gen_x[k];
                y = gen_y[k];
                z = gen_z[k];
            end
            else
            begin
                x = rand_coord();
                y = rand_coord();
                z = rand_coord();
            end
            push_vertex(x, y, z, $urandom_range(0, 20'hFFFFF), i == nv - 1);
            // a load in the middle of a face must not disturb its sums
            if (i < nv - 1 && $urandom_range(0, 9) == 0)
                push_load($urandom_range(0, 63), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic random_phase(input int count, input int lim);
        int start;
        int r;
        int k;
        start = queued;
        while (queued - start < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                k = $urandom_range(0, 63);
                // copies of other slots give distance ties
                if ($urandom_range(0, 2) == 0)
                    push_load($urandom_range(0, 63), gen_x[k], gen_y[k], gen_z[k]);
                else
                    push_load($urandom_range(0, 63), rand_coord(), rand_coord(), rand_coord());
            end
            else if (r < 87)
            begin
                push_face($urandom_range(1, MAX_VERTS_DEF), lim);
            end
            else
            begin
                push_face($urandom_range(MAX_VERTS_DEF + 1, MAX_VERTS_DEF + 3), lim);
            end
        end
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || s_tvalid || expected_assign.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_source_count(input int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v[NS_W-1:0];
        ns_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int ns_plan[$];
        int v;
        ns_plan = '{127, 2, 64, 1, 37, 100, 63, 65};
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        vert_count = 0;
        ns_reg = 1;
        tx_calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero count searches one slot
        set_source_count(0);
        push_load(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        push_load(63, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        push_load(0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh0);
        push_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 20'h0, 1'b1);
        push_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 20'hFFFFF, 1'b1);
        for (int i = 0; i < MAX_VERTS_DEF; i++)
            push_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 20'hA5A5A,
                        i == MAX_VERTS_DEF - 1);
        for (int i = 0; i < MAX_VERTS_DEF; i++)
            push_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 20'h5A5A5,
                        i == MAX_VERTS_DEF - 1);
        // extra vertices past the limit are not summed
        for (int i = 0; i < MAX_VERTS_DEF + 2; i++)
            push_vertex(rand_coord(), rand_coord(), rand_coord(), 20'h12345,
                        i == MAX_VERTS_DEF + 1);
        push_vertex(32'sh00010000, 32'sh0, 32'shFFFF0000, 20'h00001, 1'b0);
        push_load(5, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        push_vertex(32'sh00020000, 32'sh0, 32'shFFFE0000, 20'hFFFFE, 1'b1);

        // fill every slot before wider searches
        tx_calm = 1'b1;
        for (int s = 0; s < MAX_SOURCES_DEF; s++)
            push_load(s, rand_coord(), rand_coord(), rand_coord());

        ns_plan.insert(ns_plan.size(), int'($urandom_range(0, 127)));
        foreach (ns_plan[p])
        begin
            wait_idle();
            v = ns_plan[p];
            set_source_count(v);
            tx_calm = ($urandom_range(0, 3) == 0);
            random_phase(135, searched_count(v));
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/nsfa_pkg.sv
hw/rtl/nsfa_front.sv
hw/rtl/nsfa_queue.sv
hw/rtl/nsfa_back.sv
hw/rtl/nearest_source_face_assign_core.sv
test/tb.sv
